// ----- sv/dgl_pkg.sv -----
// shared types and constants for the diagonal gaussian likelihood block
package dgl_pkg;

  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W = 40;
  localparam int DVS_W = 33;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [1:0] ST_DENSITY = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_ZERO_VAR = 2'd2;
  localparam logic [1:0] ST_LEN_ERR = 2'd3;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [16:0] LN_TWO_PI_Q16 = 17'd120447;
  localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [63:0] EXP_HI_LIM = 64'sd47632711552;
  localparam logic signed [63:0] EXP_LO_OFS = 64'sd142898134656;
  localparam logic [5:0] EXP_LOW_STEPS = 6'd48;
  localparam logic [4:0] LN_SQ_STEPS = 5'd20;
  localparam logic [4:0] TAYLOR_TERMS = 5'd14;

  typedef struct packed {
    logic               action;
    logic [3:0]         dim_index;
    logic signed [31:0] mean_value;
    logic [31:0]        variance_value;
    logic signed [31:0] sample_value;
    logic               last_element;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] density;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- sv/dgl_mul.sv -----
// shared registered multiplier
module dgl_mul (
  input  logic                       clk,
  input  logic [dgl_pkg::MUL_W-1:0]  op_a,
  input  logic [dgl_pkg::MUL_W-1:0]  op_b,
  output logic [dgl_pkg::PROD_W-1:0] prod
);
  import dgl_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- sv/dgl_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module dgl_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dgl_pkg::div_req_t   req,
  output dgl_pkg::div_rsp_t   rsp
);
  import dgl_pkg::*;

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[DVS_W-1:0], q_r[DVD_W-1]};
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      busy_nxt = (cnt_r != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.quot = q_r;
  assign rsp.rem = rem_r[DVS_W-1:0];

endmodule

// ----- sv/diagonal_gaussian_likelihood_top.sv -----
// diagonal gaussian density: sequencer, parameter tables and accumulator
//
//   channel | direction | payload
//   in_     | in        | in_beat_t: load parameters or one sample element
//   out_    | out       | out_beat_t: status and density
//   cfg_    | in        | dimension count, 5 bits
//
// a load beat runs the reciprocal divide, normalizes the variance, takes
// 20 squaring steps of the log and then scales, writes and queues the
// result; a sample element passes through the shared multiplier, or goes
// straight to the end state when it lies past k; a last element adds an
// exponential: 6 compare-subtract steps to split off multiples of ln2, then
// 14 series terms, each a multiply and a divide.
// in_ready is high only while the sequencer is idle.
// reset clears control state, the accumulator and the counter; the tables
// are not cleared. a finished result waits in the output register.
module diagonal_gaussian_likelihood_top #(
  parameter int MAX_DIMENSIONS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dgl_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dgl_pkg::out_beat_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  import dgl_pkg::*;

  localparam int AW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam logic [6:0] MAXD = 7'(MAX_DIMENSIONS);

  typedef enum logic [26:0] {
    S_IDLE    = 27'h0000001,
    S_LD_DIV  = 27'h0000002,
    S_LD_DW   = 27'h0000004,
    S_LN_NORM = 27'h0000008,
    S_LN_SQ   = 27'h0000010,
    S_LN_SW   = 27'h0000020,
    S_LN_SR   = 27'h0000040,
    S_LN_SCL  = 27'h0000080,
    S_LN_LW   = 27'h0000100,
    S_LN_RND  = 27'h0000200,
    S_SM_SUB  = 27'h0000400,
    S_SM_W1   = 27'h0000800,
    S_SM_SQ   = 27'h0001000,
    S_SM_W2   = 27'h0002000,
    S_SM_HI   = 27'h0004000,
    S_SM_W3   = 27'h0008000,
    S_SM_LO   = 27'h0010000,
    S_SM_LV   = 27'h0020000,
    S_SM_END  = 27'h0040000,
    S_EX_Y    = 27'h0080000,
    S_EX_QW   = 27'h0100000,
    S_EX_TM   = 27'h0200000,
    S_EX_TW   = 27'h0400000,
    S_EX_TP   = 27'h0800000,
    S_EX_DW   = 27'h1000000,
    S_EX_SH   = 27'h2000000,
    S_DONE    = 27'h4000000
  } state_t;

  function automatic logic signed [47:0] add_sat48(logic signed [47:0] a,
                                                   logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
    return s[47:0];
  endfunction

  state_t state_r, state_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic [31:0] x_r, x_nxt;
  logic        last_r, last_nxt;
  logic [31:0] var_r, var_nxt;
  logic [31:0] mean_in_r, mean_in_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [MUL_W-1:0] op_a_r, op_a_nxt, op_b_r, op_b_nxt;
  logic [31:0] m_r, m_nxt;
  logic [4:0]  p_r, p_nxt;
  logic [19:0] frac_r, frac_nxt;
  logic [4:0]  it_r, it_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] inv_r, inv_nxt;
  logic [15:0] sq_lo_r, sq_lo_nxt;
  logic [64:0] hi_r, hi_nxt;
  logic [5:0]  q_r, q_nxt;
  logic [31:0] r_r, r_nxt;
  logic [37:0] ey_r, ey_nxt;
  logic [32:0] term_r, term_nxt;
  logic [33:0] sum_r, sum_nxt;
  out_beat_t   res_r, res_nxt;
  out_beat_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] mean_mem [MAX_DIMENSIONS];
  logic [31:0] inv_mem [MAX_DIMENSIONS];
  logic [31:0] lnv_mem [MAX_DIMENSIONS];
  logic [31:0] rd_mean_r, rd_inv_r, rd_lnv_r;
  logic        mem_we;
  logic [31:0] ln_val;

  logic [PROD_W-1:0] prod;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [32:0] diff;
  logic [32:0]  abs_diff;
  logic signed [25:0] l2;
  logic [25:0]  l2_mag;
  logic [PROD_W-1:0] ln_rnd;
  logic [31:0]  low_part;
  logic [48:0]  term_sum;
  logic [47:0]  elem_t;
  logic signed [63:0] acc_ext, y_val, y_ofs;
  logic [4:0]   cnt_inc;
  logic [21:0]  k_ln;
  logic [6:0]   sh;
  logic [33:0]  shifted;
  logic [37:0]  ln2_sh, ey_dif;
  logic         ey_ge;

  dgl_mul u_mul (
    .clk  (clk),
    .op_a (op_a_r),
    .op_b (op_b_r),
    .prod (prod)
  );

  dgl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // parameter tables, one read port addressed by the element counter
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mean_mem[AW'(idx_r)] <= mean_in_r;
      inv_mem[AW'(idx_r)] <= inv_r;
      lnv_mem[AW'(idx_r)] <= ln_val;
    end
    rd_mean_r <= mean_mem[AW'(cnt_r)];
    rd_inv_r <= inv_mem[AW'(cnt_r)];
    rd_lnv_r <= lnv_mem[AW'(cnt_r)];
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    x_nxt = x_r;
    last_nxt = last_r;
    var_nxt = var_r;
    mean_in_nxt = mean_in_r;
    idx_nxt = idx_r;
    op_a_nxt = op_a_r;
    op_b_nxt = op_b_r;
    m_nxt = m_r;
    p_nxt = p_r;
    frac_nxt = frac_r;
    it_nxt = it_r;
    neg_nxt = neg_r;
    inv_nxt = inv_r;
    sq_lo_nxt = sq_lo_r;
    hi_nxt = hi_r;
    q_nxt = q_r;
    r_nxt = r_r;
    ey_nxt = ey_r;
    term_nxt = term_r;
    sum_nxt = sum_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;

    diff = $signed({x_r[31], x_r}) - $signed({rd_mean_r[31], rd_mean_r});
    abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
    l2 = $signed({6'($signed({1'b0, p_r}) - 6'sd16), 20'b0}) + $signed({6'b0, frac_r});
    l2_mag = l2[25] ? 26'(-l2) : 26'(l2);
    ln_rnd = prod + (PROD_W'(1) << 35);
    ln_val = neg_r ? 32'(-ln_rnd[65:36]) : 32'(ln_rnd[65:36]);
    low_part = prod[47:16];
    term_sum = {1'b0, hi_r[47:0]} + {17'b0, low_part};
    if (hi_r >= 65'(ACC_MAX)) begin
      elem_t = ACC_MAX;
    end else if (term_sum > 49'(ACC_MAX)) begin
      elem_t = ACC_MAX;
    end else begin
      elem_t = term_sum[47:0];
    end
    acc_ext = 64'(acc_r);
    y_val = (-acc_ext) <<< 15;
    y_ofs = y_val + EXP_LO_OFS;
    cnt_inc = (cnt_r != 5'd31) ? cnt_r + 5'd1 : cnt_r;
    k_ln = 22'(k_r) * 22'(LN_TWO_PI_Q16);
    sh = 7'd64 - {1'b0, q_r};
    shifted = sum_r >> sh[5:0];
    ln2_sh = 38'(LN2_Q32) << it_r[2:0];
    ey_ge = (ey_r >= ln2_sh);
    ey_dif = ey_ge ? ey_r - ln2_sh : ey_r;

    if (cfg_valid) begin
      k_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_data.sample_value;
          last_nxt = in_data.last_element;
          var_nxt = in_data.variance_value;
          mean_in_nxt = in_data.mean_value;
          idx_nxt = in_data.dim_index;
          if (in_data.action == ACT_LOAD) begin
            res_nxt.density = '0;
            if (in_data.variance_value == '0) begin
              res_nxt.status = ST_ZERO_VAR;
              state_nxt = S_DONE;
            end else if ({3'b0, in_data.dim_index} >= MAXD) begin
              res_nxt.status = ST_LOADED;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_LD_DIV;
            end
          end else if (cnt_r < k_r && {2'b0, cnt_r} < MAXD) begin
            state_nxt = S_SM_SUB;
          end else begin
            state_nxt = S_SM_END;
          end
        end
      end
      S_LD_DIV: begin
        div_req.start = 1'b1;
        div_req.dividend = DVD_W'(64'h1_0000_0000);
        div_req.divisor = DVS_W'(var_r);
        state_nxt = S_LD_DW;
      end
      S_LD_DW: begin
        if (!div_rsp.busy) begin
          inv_nxt = (div_rsp.quot > DVD_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                           : div_rsp.quot[31:0];
          m_nxt = var_r;
          p_nxt = 5'd31;
          frac_nxt = '0;
          it_nxt = '0;
          state_nxt = S_LN_NORM;
        end
      end
      S_LN_NORM: begin
        if (m_r[31] || p_r == '0) begin
          state_nxt = S_LN_SQ;
        end else begin
          m_nxt = {m_r[30:0], 1'b0};
          p_nxt = p_r - 5'd1;
        end
      end
      S_LN_SQ: begin
        op_a_nxt = MUL_W'(m_r);
        op_b_nxt = MUL_W'(m_r);
        state_nxt = S_LN_SW;
      end
      S_LN_SW: state_nxt = S_LN_SR;
      S_LN_SR: begin
        // square in 1.31, renormalize and shift out one bit of log2
        frac_nxt = {frac_r[18:0], prod[63]};
        m_nxt = prod[63] ? prod[63:32] : prod[62:31];
        it_nxt = it_r + 5'd1;
        state_nxt = (it_r == LN_SQ_STEPS - 5'd1) ? S_LN_SCL : S_LN_SQ;
      end
      S_LN_SCL: begin
        neg_nxt = l2[25];
        op_a_nxt = MUL_W'(l2_mag);
        op_b_nxt = MUL_W'(LN2_Q32);
        state_nxt = S_LN_LW;
      end
      S_LN_LW: state_nxt = S_LN_RND;
      S_LN_RND: begin
        mem_we = 1'b1;
        res_nxt.status = ST_LOADED;
        res_nxt.density = '0;
        state_nxt = S_DONE;
      end
      S_SM_SUB: begin
        op_a_nxt = abs_diff;
        op_b_nxt = abs_diff;
        state_nxt = S_SM_W1;
      end
      S_SM_W1: state_nxt = S_SM_SQ;
      S_SM_SQ: begin
        // d^2 kept as Q33.16, split into a 33-bit integer part and a 16-bit fraction
        sq_lo_nxt = prod[31:16];
        op_a_nxt = prod[64:32];
        op_b_nxt = MUL_W'(rd_inv_r);
        state_nxt = S_SM_W2;
      end
      S_SM_W2: state_nxt = S_SM_HI;
      S_SM_HI: begin
        hi_nxt = prod[64:0];
        op_a_nxt = MUL_W'(sq_lo_r);
        op_b_nxt = MUL_W'(rd_inv_r);
        state_nxt = S_SM_W3;
      end
      S_SM_W3: state_nxt = S_SM_LO;
      S_SM_LO: begin
        acc_nxt = add_sat48(acc_r, $signed(elem_t));
        state_nxt = S_SM_LV;
      end
      S_SM_LV: begin
        acc_nxt = add_sat48(acc_r, 48'($signed(rd_lnv_r)));
        state_nxt = S_SM_END;
      end
      S_SM_END: begin
        if (!last_r) begin
          cnt_nxt = cnt_inc;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = '0;
          if (cnt_inc != k_r || k_r == '0 || {2'b0, k_r} > MAXD) begin
            acc_nxt = '0;
            res_nxt.status = ST_LEN_ERR;
            res_nxt.density = '0;
            state_nxt = S_DONE;
          end else begin
            acc_nxt = add_sat48(acc_r, $signed(48'(k_ln)));
            state_nxt = S_EX_Y;
          end
        end
      end
      S_EX_Y: begin
        acc_nxt = '0;
        res_nxt.status = ST_DENSITY;
        if (y_val >= EXP_HI_LIM) begin
          res_nxt.density = 32'hFFFF_FFFF;
          state_nxt = S_DONE;
        end else if (y_val < -EXP_LO_OFS) begin
          res_nxt.density = '0;
          state_nxt = S_DONE;
        end else begin
          // split y into n*ln2 + r with n offset into the positive range
          ey_nxt = 38'(y_ofs);
          q_nxt = '0;
          it_nxt = 5'd5;
          state_nxt = S_EX_QW;
        end
      end
      S_EX_QW: begin
        // one quotient bit per cycle against ln2 scaled by 32 down to 1
        ey_nxt = ey_dif;
        q_nxt = {q_r[4:0], ey_ge};
        if (it_r == '0) begin
          r_nxt = ey_dif[31:0];
          term_nxt = 33'h1_0000_0000;
          sum_nxt = 34'h1_0000_0000;
          it_nxt = 5'd1;
          state_nxt = S_EX_TM;
        end else begin
          it_nxt = it_r - 5'd1;
        end
      end
      S_EX_TM: begin
        op_a_nxt = term_r;
        op_b_nxt = MUL_W'(r_r);
        state_nxt = S_EX_TW;
      end
      S_EX_TW: state_nxt = S_EX_TP;
      S_EX_TP: begin
        div_req.start = 1'b1;
        div_req.dividend = DVD_W'(prod[65:32]);
        div_req.divisor = DVS_W'(it_r);
        state_nxt = S_EX_DW;
      end
      S_EX_DW: begin
        if (!div_rsp.busy) begin
          term_nxt = div_rsp.quot[32:0];
          sum_nxt = sum_r + 34'(div_rsp.quot[32:0]);
          it_nxt = it_r + 5'd1;
          state_nxt = (it_r == TAYLOR_TERMS) ? S_EX_SH : S_EX_TM;
        end
      end
      S_EX_SH: begin
        if (q_r == '0) begin
          res_nxt.density = '0;
        end else if (shifted > 34'h0_FFFF_FFFF) begin
          res_nxt.density = 32'hFFFF_FFFF;
        end else begin
          res_nxt.density = shifted[31:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= 5'd1;
      cnt_r <= '0;
      acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r <= x_nxt;
    last_r <= last_nxt;
    var_r <= var_nxt;
    mean_in_r <= mean_in_nxt;
    idx_r <= idx_nxt;
    op_a_r <= op_a_nxt;
    op_b_r <= op_b_nxt;
    m_r <= m_nxt;
    p_r <= p_nxt;
    frac_r <= frac_nxt;
    it_r <= it_nxt;
    neg_r <= neg_nxt;
    inv_r <= inv_nxt;
    sq_lo_r <= sq_lo_nxt;
    hi_r <= hi_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    ey_r <= ey_nxt;
    term_r <= term_nxt;
    sum_r <= sum_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
